// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that expr holds in the cycle after cond.
`define ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, (cond) |=> (expr), msg)

// Check that expr holds in the same cycle as cond.
`define ASSERT_SAME(lbl, clk, rst, cond, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, (cond) |-> (expr), msg)

`endif

// File: hw/rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrpt_pkg;

   // Port width of the candidate and width of the arithmetic
   localparam int CAND_WIDTH = 62;
   localparam int NUM_WIDTH  = 62;

   // Witness bases
   localparam int BASE_COUNT = 7;
   localparam int IDX_WIDTH  = $clog2(BASE_COUNT + 1);
   localparam int BASE_WIDTH = 5;

   // Counts of factors of two in candidate - 1
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

   typedef logic [NUM_WIDTH-1:0] num_type;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SPLIT    = 11'b000_0000_0010,
      ST_BASE     = 11'b000_0000_0100,
      ST_POW_BIT  = 11'b000_0000_1000,
      ST_MUL_X    = 11'b000_0001_0000,
      ST_POW_SQR  = 11'b000_0010_0000,
      ST_MUL_B    = 11'b000_0100_0000,
      ST_CHECK    = 11'b000_1000_0000,
      ST_SQR_TEST = 11'b001_0000_0000,
      ST_MUL_R    = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   // Witness base by index; past the last base it reads as zero
   function automatic logic [BASE_WIDTH-1:0] witness_base(input logic [IDX_WIDTH-1:0] idx);
      logic [BASE_WIDTH-1:0] b;
      unique case (idx)
         IDX_WIDTH'(0): b = BASE_WIDTH'(2);
         IDX_WIDTH'(1): b = BASE_WIDTH'(3);
         IDX_WIDTH'(2): b = BASE_WIDTH'(5);
         IDX_WIDTH'(3): b = BASE_WIDTH'(7);
         IDX_WIDTH'(4): b = BASE_WIDTH'(11);
         IDX_WIDTH'(5): b = BASE_WIDTH'(13);
         IDX_WIDTH'(6): b = BASE_WIDTH'(17);
         default:       b = '0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/miller_rabin_prime_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Miller-Rabin strong probable-prime test of one unsigned number.
// Request channel: req_candidate with req_valid / req_stall. The low NUM_WIDTH
// bits are tested; higher bits are ignored. req_stall is high whenever a
// request is in work or its response is waiting, so one request at a time.
// Response channel: rsp_prime_flag with rsp_valid / rsp_stall. The flag is 1
// when the number passes bases 2, 3, 5, 7, 11, 13 and 17 (bases not below the
// number are skipped); exact below 341550071728321.
// 0, 1, 2 and even numbers answer in the cycle after acceptance. Odd numbers
// are first split as n - 1 = d * 2^s by repeated halving of d, then per base
// take one modular power over the bits of d plus up to s - 1 squarings. Each
// modular multiply handles each bit of its multiplier as an add step and a
// double step, since one add-and-reduce adder serves both the add and the double
// of every bit. A 62-bit candidate whose d is all ones takes up to 7 * 122
// multiplies; typical smaller numbers take far fewer.
// Reset (synchronous, active high) returns the sequencer to idle and drops any
// request in work. While rsp_stall is high the response and its flag hold, and
// no new request is taken until the response is accepted.
module miller_rabin_prime_test_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mrpt_pkg::CAND_WIDTH-1:0] req_candidate,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_prime_flag
);

   localparam int NW = mrpt_pkg::NUM_WIDTH;
   localparam int CW = mrpt_pkg::CNT_WIDTH;
   localparam int IW = mrpt_pkg::IDX_WIDTH;
   localparam int BW = mrpt_pkg::BASE_WIDTH;

   mrpt_pkg::state_type state_ff, state_in;

   mrpt_pkg::num_type n_ff, n_in;
   mrpt_pkg::num_type d_ff, d_in;
   mrpt_pkg::num_type x_ff, x_in;
   mrpt_pkg::num_type b_ff, b_in;
   mrpt_pkg::num_type e_ff, e_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [CW-1:0]     r_ff, r_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              flag_ff, flag_in;

   mrpt_pkg::num_type mul_acc_ff, mul_acc_in;
   mrpt_pkg::num_type mul_x_ff, mul_x_in;
   mrpt_pkg::num_type mul_y_ff, mul_y_in;
   logic              mul_phase_ff, mul_phase_in;

   mrpt_pkg::num_type cand;
   mrpt_pkg::num_type nm1;
   mrpt_pkg::num_type base_ext;
   mrpt_pkg::num_type add_a;
   mrpt_pkg::num_type add_result;
   logic [NW:0]       add_sum;
   logic [NW+1:0]     add_diff;
   logic              base_done;
   logic              sqr_last;
   logic              mul_active;
   logic              mul_done;

   assign cand     = req_candidate[NW-1:0];
   assign nm1      = {n_ff[NW-1:1], 1'b0};
   assign base_ext = {{(NW - BW){1'b0}}, mrpt_pkg::witness_base(idx_ff)};
   assign base_done = (idx_ff == IW'(mrpt_pkg::BASE_COUNT)) || (base_ext >= n_ff);
   assign sqr_last  = (CW'(r_ff + CW'(1)) == s_ff);

   // Shared add-and-reduce: phase 0 adds x into acc, phase 1 doubles x
   assign add_a      = mul_phase_ff ? mul_x_ff : mul_acc_ff;
   assign add_sum    = {1'b0, add_a} + {1'b0, mul_x_ff};
   assign add_diff   = {1'b0, add_sum} - {2'b00, n_ff};
   assign add_result = add_diff[NW+1] ? add_sum[NW-1:0] : add_diff[NW-1:0];

   assign mul_active = (state_ff == mrpt_pkg::ST_MUL_X) || (state_ff == mrpt_pkg::ST_MUL_B) ||
                       (state_ff == mrpt_pkg::ST_MUL_R);
   assign mul_done   = !mul_phase_ff && (mul_y_ff == '0);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      flag_in      = flag_ff;
      mul_acc_in   = mul_acc_ff;
      mul_x_in     = mul_x_ff;
      mul_y_in     = mul_y_ff;
      mul_phase_in = mul_phase_ff;

      // Advance the modular multiply by one half-step
      if (mul_active && !mul_done) begin
         if (!mul_phase_ff) begin
            if (mul_y_ff[0]) begin
               mul_acc_in = add_result;
            end
            mul_phase_in = 1'b1;
         end else begin
            mul_x_in     = add_result;
            mul_y_in     = {1'b0, mul_y_ff[NW-1:1]};
            mul_phase_in = 1'b0;
         end
      end

      unique case (state_ff)
         mrpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               n_in = cand;
               priority if (cand == NW'(2)) begin
                  flag_in  = 1'b1;
                  state_in = mrpt_pkg::ST_DONE;
               end else if ((cand[NW-1:1] == '0) || !cand[0]) begin
                  flag_in  = 1'b0;
                  state_in = mrpt_pkg::ST_DONE;
               end else begin
                  d_in     = {1'b0, cand[NW-1:1]};
                  s_in     = CW'(1);
                  state_in = mrpt_pkg::ST_SPLIT;
               end
            end
         end
         mrpt_pkg::ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[NW-1:1]};
               s_in = CW'(s_ff + CW'(1));
            end else begin
               idx_in   = '0;
               state_in = mrpt_pkg::ST_BASE;
            end
         end
         mrpt_pkg::ST_BASE: begin
            if (base_done) begin
               flag_in  = 1'b1;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               x_in     = NW'(1);
               b_in     = base_ext;
               e_in     = d_ff;
               state_in = mrpt_pkg::ST_POW_BIT;
            end
         end
         mrpt_pkg::ST_POW_BIT: begin
            priority if (e_ff == '0) begin
               state_in = mrpt_pkg::ST_CHECK;
            end else if (e_ff[0]) begin
               mul_acc_in   = '0;
               mul_x_in     = x_ff;
               mul_y_in     = b_ff;
               mul_phase_in = 1'b0;
               state_in     = mrpt_pkg::ST_MUL_X;
            end else begin
               state_in = mrpt_pkg::ST_POW_SQR;
            end
         end
         mrpt_pkg::ST_MUL_X: begin
            if (mul_done) begin
               x_in     = mul_acc_ff;
               state_in = mrpt_pkg::ST_POW_SQR;
            end
         end
         mrpt_pkg::ST_POW_SQR: begin
            mul_acc_in   = '0;
            mul_x_in     = b_ff;
            mul_y_in     = b_ff;
            mul_phase_in = 1'b0;
            state_in     = mrpt_pkg::ST_MUL_B;
         end
         mrpt_pkg::ST_MUL_B: begin
            if (mul_done) begin
               b_in     = mul_acc_ff;
               e_in     = {1'b0, e_ff[NW-1:1]};
               state_in = mrpt_pkg::ST_POW_BIT;
            end
         end
         mrpt_pkg::ST_CHECK: begin
            if (x_ff == NW'(1)) begin
               idx_in   = IW'(idx_ff + IW'(1));
               state_in = mrpt_pkg::ST_BASE;
            end else begin
               r_in     = '0;
               state_in = mrpt_pkg::ST_SQR_TEST;
            end
         end
         mrpt_pkg::ST_SQR_TEST: begin
            priority if (x_ff == nm1) begin
               idx_in   = IW'(idx_ff + IW'(1));
               state_in = mrpt_pkg::ST_BASE;
            end else if (sqr_last) begin
               flag_in  = 1'b0;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               mul_acc_in   = '0;
               mul_x_in     = x_ff;
               mul_y_in     = x_ff;
               mul_phase_in = 1'b0;
               state_in     = mrpt_pkg::ST_MUL_R;
            end
         end
         mrpt_pkg::ST_MUL_R: begin
            if (mul_done) begin
               x_in     = mul_acc_ff;
               r_in     = CW'(r_ff + CW'(1));
               state_in = mrpt_pkg::ST_SQR_TEST;
            end
         end
         mrpt_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = mrpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrpt_pkg::ST_IDLE;
         end
      endcase
   end

   // Return control state to idle under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      x_ff         <= x_in;
      b_ff         <= b_in;
      e_ff         <= e_in;
      s_ff         <= s_in;
      r_ff         <= r_in;
      idx_ff       <= idx_in;
      flag_ff      <= flag_in;
      mul_acc_ff   <= mul_acc_in;
      mul_x_ff     <= mul_x_in;
      mul_y_ff     <= mul_y_in;
      mul_phase_ff <= mul_phase_in;
   end

   assign req_stall      = (state_ff != mrpt_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == mrpt_pkg::ST_DONE);
   assign rsp_prime_flag = flag_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mrpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrpt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_prime_flag
);

   logic req_fire;
   logic rsp_fire;
   logic rsp_wait;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

   // A waiting response keeps the request side closed
   `ASSERT_SAME(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall, "request while busy")
   // An accepted request closes the request side
   `ASSERT_NEXT(a_req_closes, clock, reset, req_fire, req_stall, "request side open after accept")
   // A delivered response reopens the request side
   `ASSERT_NEXT(a_rsp_reopens, clock, reset, rsp_fire, !req_stall && !rsp_valid, "not idle")
   // A stalled response holds its flag
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_prime_flag), "moved")

endmodule

bind miller_rabin_prime_test_unit mrpt_checker u_mrpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_prime_flag (rsp_prime_flag)
);

`default_nettype wire

// File: bench/miller_rabin_prime_test_unit_tb.sv
`timescale 1ns / 1ps

module miller_rabin_prime_test_unit_tb;

   typedef logic [63:0] word64_type;

   // One row of the directed table: known = 1 means the flag is typed in
   typedef struct packed {
      mrpt_pkg::num_type candidate;
      logic              known;
      logic              flag;
   } probe_row_type;

   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_COUNT   = 80;
   localparam int CALM_TAIL      = 20;
   localparam int DRAIN_CYCLES   = 40;
   // Longest run with no request or response accepted before the bench gives up
   localparam int WATCHDOG_LIMIT = 800000;

   localparam word64_type WITNESSES [mrpt_pkg::BASE_COUNT] = '{
      64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [mrpt_pkg::CAND_WIDTH-1:0] req_candidate;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_prime_flag;

   // Flag expected for the request currently on the port
   logic next_flag;
   logic calm;

   logic pending_flags [$];
   int   error_count;
   int   checked_count;
   int   prime_count;
   int   idle_cycles;
   int   stall_left;

   probe_row_type directed_probes [DIRECTED_COUNT] = '{
      '{62'd0,                   1'b1, 1'b0},
      '{62'd1,                   1'b1, 1'b0},
      '{62'd2,                   1'b1, 1'b1},
      '{62'd3,                   1'b1, 1'b1},
      '{62'd4,                   1'b1, 1'b0},
      '{62'd18,                  1'b1, 1'b0},
      '{62'd5,                   1'b0, 1'b0},
      '{62'd9,                   1'b0, 1'b0},
      '{62'd15,                  1'b0, 1'b0},
      '{62'd17,                  1'b0, 1'b0},
      '{62'd25,                  1'b0, 1'b0},
      '{62'd561,                 1'b0, 1'b0},
      '{62'd2047,                1'b0, 1'b0},
      '{62'd3215031751,          1'b0, 1'b0},
      '{62'd2147483647,          1'b0, 1'b0},
      '{62'd341550071728321,     1'b0, 1'b0},
      '{62'd2305843009213693952, 1'b1, 1'b0},
      '{62'd4611686018427387902, 1'b1, 1'b0},
      '{62'd4611686018427387903, 1'b0, 1'b0},
      '{62'd4611686018427387847, 1'b0, 1'b0}
   };

   miller_rabin_prime_test_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_candidate  (req_candidate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sum of two residues, reduced once
   function automatic word64_type mod_sum(input word64_type x, input word64_type y,
                                          input word64_type m);
      word64_type t;
      t = x + y;
      if (t >= m) t = t - m;
      return t;
   endfunction

   // Product mod m by add-and-double
   function automatic word64_type mod_product(input word64_type x, input word64_type y,
                                              input word64_type m);
      word64_type acc;
      acc = 64'd0;
      while (y != 64'd0) begin
         if (y[0]) acc = mod_sum(acc, x, m);
         x = mod_sum(x, x, m);
         y = y >> 1;
      end
      return acc;
   endfunction

   // Power mod m by square-and-multiply
   function automatic word64_type mod_power(input word64_type b, input word64_type e,
                                            input word64_type m);
      word64_type acc;
      acc = 64'd1;
      while (e != 64'd0) begin
         if (e[0]) acc = mod_product(acc, b, m);
         b = mod_product(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Strong probable-prime verdict over the fixed witness set
   function automatic logic predict_prime_flag(input mrpt_pkg::num_type cand);
      word64_type n;
      word64_type d;
      word64_type x;
      int         s;
      int         r;
      logic       passed;
      logic       composite;
      n = 64'(cand[mrpt_pkg::NUM_WIDTH-1:0]);
      if (n == 64'd2) return 1'b1;
      if (n <= 64'd1 || !n[0]) return 1'b0;
      d = n - 64'd1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      composite = 1'b0;
      for (int i = 0; i < mrpt_pkg::BASE_COUNT; i++) begin
         if (!composite && WITNESSES[i] < n) begin
            x = mod_power(WITNESSES[i], d, n);
            passed = (x == 64'd1);
            for (r = 0; r < s; r++) begin
               if (!passed && x == n - 64'd1) passed = 1'b1;
               x = mod_product(x, x, n);
            end
            if (!passed) composite = 1'b1;
         end
      end
      return !composite;
   endfunction

   // Mostly small odd numbers; a few wide ones and some even ones
   function automatic mrpt_pkg::num_type random_candidate();
      word64_type        raw;
      int unsigned       pick;
      int unsigned       bits;
      mrpt_pkg::num_type cand;
      pick = $urandom_range(0, 99);
      if (pick < 55)      bits = $urandom_range(2, 16);
      else if (pick < 80) bits = $urandom_range(17, 32);
      else if (pick < 94) bits = $urandom_range(33, 48);
      else                bits = $urandom_range(49, 62);
      raw  = {$urandom, $urandom};
      cand = mrpt_pkg::num_type'(raw & ((64'd1 << bits) - 64'd1));
      cand[bits-1] = 1'b1;
      cand[0] = ($urandom_range(0, 99) >= 15);
      return cand;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] ERROR: %s", $realtime, what);
      error_count++;
   endtask

   // Present one request and hold it until taken; optionally drop valid a while
   task automatic offer_candidate(input mrpt_pkg::num_type cand, input logic flag,
                                  input logic with_gaps);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_candidate <= cand;
      next_flag     <= flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (with_gaps && $urandom_range(0, 1) == 1) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stall the response side in random bursts, except in the calm tail
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Track requests and responses, check each response, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_flags.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               if (rsp_prime_flag !== pending_flags[0])
                  report_mismatch($sformatf("prime_flag %b, expected %b",
                                            rsp_prime_flag, pending_flags[0]));
               if (pending_flags[0]) prime_count++;
               void'(pending_flags.pop_front());
               checked_count++;
            end
         end
         if (req_valid && !req_stall) pending_flags.push_back(next_flag);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: nothing moved for %0d cycles", $realtime, idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      probe_row_type     row;
      mrpt_pkg::num_type cand;
      reset         = 1'b1;
      calm          = 1'b0;
      req_valid     = 1'b0;
      req_candidate = '0;
      next_flag     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_probes[i];
         offer_candidate(row.candidate,
                         row.known ? row.flag : predict_prime_flag(row.candidate), 1'b1);
      end

      // Hold off until the block has answered everything
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_flags.size() != 0);

      // Random requests, quiet on both sides toward the end
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         if (k == RANDOM_COUNT - CALM_TAIL) calm <= 1'b1;
         cand = random_candidate();
         offer_candidate(cand, predict_prime_flag(cand), k < RANDOM_COUNT - CALM_TAIL);
      end
      req_valid <= 1'b0;

      // Drain outstanding responses
      do @(posedge clock); while (pending_flags.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d table rows and %0d random candidates up to 62 bits.",
               DIRECTED_COUNT, RANDOM_COUNT);
      $display("Checked %0d responses, %0d of them prime, under random stalls on both sides.",
               checked_count, prime_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
